// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset implication failed");

`endif

// ===== rtl/fqs_pkg.sv =====
// Types, constants and helpers for the queue-with-search block.
// No dependencies.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SEARCH
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
  } fqs_req_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [4:0]         position;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic [4:0]         occupancy;
  } fqs_rsp_t;

  function automatic idx_t fqs_wrap(input idx_t idx);
    return (idx == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Build a result; front and rear read as zero on an empty queue.
  function automatic fqs_rsp_t fqs_report(input status_t status,
                                          input logic found,
                                          input cnt_t position,
                                          input logic signed [VALUE_BITS-1:0] front,
                                          input logic signed [VALUE_BITS-1:0] rear,
                                          input cnt_t count);
    fqs_rsp_t r;
    r.status      = status;
    r.found       = found;
    r.position    = position[4:0];
    r.front_value = (count == '0) ? '0 : front[31:0];
    r.rear_value  = (count == '0) ? '0 : rear[31:0];
    r.is_empty    = (count == '0);
    r.occupancy   = count[4:0];
    return r;
  endfunction

endpackage

// ===== rtl/fifo_queue_with_search_core.sv =====
// Top level of the bounded queue with search.
// Depends on fqs_pkg and fqs_store.
`timescale 1ns / 1ps

// Usage:
//   A request (mode, value) is taken at a clock edge where start is high and
//   busy is low. Each request yields exactly one result on the result port,
//   shown for one cycle with done high; the receiver cannot hold it off.
//   Enqueue, mode 3, and any request refused as full or empty report from
//   the idle state, and a new request is taken in that same done cycle; a
//   dequeue that leaves entries behind reports from the fetch state, once
//   the new front is read back; a search reports from the search state once
//   it finds a match or has scanned the last entry, scanning 1 to 16 entries.
//   The entries sit in a single memory with one read port and registered
//   read data; the search walks that port one entry per cycle from the
//   front. Front and rear values are held in registers beside the memory.
//   Reset clears head, tail, count and the control state; the queue starts
//   empty and memory contents are never read before they are written.
//   An enqueue writes at the edge it is accepted and later reads come at a
//   later edge, so no bypass is needed around the memory.
module fifo_queue_with_search_core
  import fqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  fqs_req_t request,
  output logic     done,
  output fqs_rsp_t result
);

  state_t state, state_next;

  idx_t head, tail, srch_ptr, srch_idx;
  cnt_t count;
  logic signed [VALUE_BITS-1:0] front_q, rear_q, value_q, value_in;
  logic signed [VALUE_BITS-1:0] rd_data;
  idx_t rd_addr;
  logic accept, wr_en, match, last;
  logic is_full, is_zero;

  assign value_in = VALUE_BITS'(request.value);
  assign is_full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign is_zero  = (count == '0);
  assign match    = (rd_data == value_q);
  assign last     = (({1'b0, srch_idx} + CNT_BITS'(1)) == count);
  assign wr_en    = accept && (request.mode == MODE_ENQ) && !is_full;

  fqs_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (value_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    accept     = start && (state == S_IDLE);
    rd_addr    = srch_ptr;
    case (state)
      S_IDLE: begin
        if (request.mode == MODE_DEQ) begin
          rd_addr = fqs_wrap(head);
        end else begin
          rd_addr = head;
        end
        if (accept) begin
          if (request.mode == MODE_DEQ && count > CNT_BITS'(1)) begin
            state_next = S_FETCH;
          end else if (request.mode == MODE_SEARCH && !is_zero) begin
            state_next = S_SEARCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (match || last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_q <= value_in;
            case (request.mode)
              MODE_ENQ: begin
                done <= 1'b1;
                if (is_full) begin
                  result <= fqs_report(ST_FULL, 1'b0, '0, front_q, rear_q, count);
                end else begin
                  tail   <= fqs_wrap(tail);
                  count  <= count + 1'b1;
                  rear_q <= value_in;
                  if (is_zero) begin
                    front_q <= value_in;
                  end
                  result <= fqs_report(ST_DONE, 1'b0, '0,
                                       is_zero ? value_in : front_q,
                                       value_in, count + 1'b1);
                end
              end
              MODE_DEQ: begin
                if (is_zero) begin
                  done   <= 1'b1;
                  result <= fqs_report(ST_EMPTY, 1'b0, '0, front_q, rear_q, count);
                end else begin
                  head  <= fqs_wrap(head);
                  count <= count - 1'b1;
                  // last entry gone: report now, else wait for the new front
                  if (count == CNT_BITS'(1)) begin
                    done   <= 1'b1;
                    result <= fqs_report(ST_DONE, 1'b0, '0, front_q, rear_q, '0);
                  end
                end
              end
              MODE_SEARCH: begin
                if (is_zero) begin
                  done   <= 1'b1;
                  result <= fqs_report(ST_EMPTY, 1'b0, '0, front_q, rear_q, count);
                end else begin
                  srch_ptr <= fqs_wrap(head);
                  srch_idx <= '0;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= fqs_report(ST_DONE, 1'b0, '0, front_q, rear_q, count);
              end
            endcase
          end
        end
        S_FETCH: begin
          front_q <= rd_data;
          done    <= 1'b1;
          result  <= fqs_report(ST_DONE, 1'b0, '0, rd_data, rear_q, count);
        end
        S_SEARCH: begin
          if (match) begin
            done   <= 1'b1;
            result <= fqs_report(ST_DONE, 1'b1, {1'b0, srch_idx} + CNT_BITS'(1),
                                 front_q, rear_q, count);
          end else if (last) begin
            done   <= 1'b1;
            result <= fqs_report(ST_DONE, 1'b0, '0, front_q, rear_q, count);
          end else begin
            // advance to the next entry; its read is already in flight
            srch_ptr <= fqs_wrap(srch_ptr);
            srch_idx <= srch_idx + 1'b1;
          end
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/fqs_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on fqs_pkg.
`timescale 1ns / 1ps

module fqs_store
  import fqs_pkg::*;
(
  input  logic                         clk,
  input  logic                         wr_en,
  input  idx_t                         wr_addr,
  input  logic signed [VALUE_BITS-1:0] wr_data,
  input  idx_t                         rd_addr,
  output logic signed [VALUE_BITS-1:0] rd_data
);

  logic signed [VALUE_BITS-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/fqs_checker.sv =====
// Port-level checks for the queue-with-search top level, with its bind.
// Depends on fqs_pkg, assert_macros.svh and fifo_queue_with_search_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqs_checker
  import fqs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input fqs_req_t request,
  input logic     done,
  input fqs_rsp_t result
);

  `ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !done && !busy)
  `ASSERT_IMPL(a_occ_bound, clk, rst, done, result.occupancy <= 5'(QUEUE_DEPTH))
  `ASSERT_IMPL(a_empty_occ, clk, rst, done, result.is_empty == (result.occupancy == 5'd0))
  `ASSERT_IMPL(a_found_pos, clk, rst, done && result.found, (result.position != 5'd0) && (result.position <= result.occupancy) && (result.status == ST_DONE))
  `ASSERT_NEXT(a_enq_one_cycle, clk, rst, start && !busy && (request.mode == MODE_ENQ), done)

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
